>>> src/repeating_loop_detector_core_assert.svh
// assertion macros for the loop detector
`ifndef REPEATING_LOOP_DETECTOR_CORE_ASSERT_SVH
`define REPEATING_LOOP_DETECTOR_CORE_ASSERT_SVH
// implication checked every clock outside reset
`define RLD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define RLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> src/rld_pkg.sv
// types and constants for the loop detector
package rld_pkg;
  localparam int unsigned IdW = 16;
  localparam int unsigned RunW = 16;
  localparam int unsigned SizeW = 9;
  localparam logic [RunW-1:0] RunMax = 16'hFFFF;
  // hierarchy levels, one per value of the level field
  localparam int unsigned Levels = 4;
  localparam int unsigned LvlW = 2;

  typedef struct packed {
    logic [15:0] event_id;
    logic [15:0] size_tag;
    logic [1:0]  level_select;
  } in_req_t;

  typedef struct packed {
    logic signed [3:0] loop_event;
    logic [8:0]        loop_size;
  } out_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // broadcast from control to every cell
  typedef struct packed {
    logic        clear;
    logic        step;
    logic [1:0]  level;
    logic [15:0] event_id;
    logic [15:0] size_tag;
  } cell_ctl_t;
endpackage

>>> src/rld_cell.sv
// one distance cell: history pairs and run counts for every level
module rld_cell (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rld_pkg::cell_ctl_t                   ctl,
  input  logic [rld_pkg::Levels-1:0][31:0]     pair_in,
  output logic [rld_pkg::Levels-1:0][31:0]     pair_out,
  output logic [15:0]                          run_out
);
  logic [rld_pkg::Levels-1:0][31:0] pair_r;
  logic [rld_pkg::Levels-1:0][15:0] run_r;
  logic [rld_pkg::LvlW-1:0]         lv;
  logic [31:0]                      cur;
  logic [15:0]                      run_nxt;

  assign lv = ctl.level[rld_pkg::LvlW-1:0];
  assign cur = {ctl.event_id, ctl.size_tag};
  always_comb begin
    if (pair_r[lv] != cur) begin
      run_nxt = '0;
    end else if (run_r[lv] == rld_pkg::RunMax) begin
      run_nxt = run_r[lv];
    end else begin
      run_nxt = run_r[lv] + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      pair_r <= '0;
      run_r  <= '0;
    end else if (ctl.step) begin
      pair_r[lv] <= pair_in[lv];
      run_r[lv]  <= run_nxt;
    end
  end

  assign pair_out = pair_r;
  assign run_out = run_r[lv];
endmodule

>>> src/rld_ctrl.sv
// loop state per level and event encoding
module rld_ctrl (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        upd,
  input  logic [1:0]  level,
  input  logic [16:0] best_run,
  input  logic [8:0]  best_d,
  input  logic [8:0]  win,
  output rld_pkg::out_req_t res
);
  logic [rld_pkg::Levels-1:0][8:0] lw_r, pw_r, ph_r;
  logic [rld_pkg::LvlW-1:0] lv;
  logic inloop, noloop, diff, newite, newlop, endlop;
  logic [8:0] w, pw, f, f0;
  logic signed [3:0] ev;

  assign lv = level[rld_pkg::LvlW-1:0];
  always_comb begin
    inloop = best_run >= {8'd0, win};
    w = lw_r[lv];
    if (!inloop) begin
      w = best_d;
      inloop = (best_d != 9'd0) && (best_run > {8'd0, best_d});
    end
    pw = pw_r[lv];
    noloop = !inloop;
    diff = pw != w;
    f0 = (diff || ph_r[lv] == w) ? 9'd0 : ph_r[lv];
    newite = inloop && (w == 9'd1 || f0 == 9'd0);
    f = inloop ? f0 + 9'd1 : f0;
    newlop = newite && diff;
    endlop = diff && pw != 9'd0;
    if (newlop) pw = w;
    if (noloop) begin
      f = '0;
      pw = '0;
    end
    ev = 4'sd0;
    if (!inloop && endlop) ev = ev - 4'sd1;
    if (inloop) ev = ev + 4'sd1;
    if (newite) ev = ev + 4'sd1;
    if (newlop) ev = ev + 4'sd1;
    if (newlop && endlop) ev = ev + 4'sd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r <= '0;
      pw_r <= '0;
      ph_r <= '0;
    end else if (upd) begin
      lw_r[lv] <= w;
      pw_r[lv] <= pw;
      ph_r[lv] <= f;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      res.loop_event <= ev;
      res.loop_size  <= pw;
    end
  end
endmodule

>>> src/repeating_loop_detector_core.sv
// top level of the repeating loop detector
// usage:
//   in_* carries one request (event id, size tag, level) with valid/ready
//   out_* returns one result per request (loop event, loop size)
//   cfg_we/cfg_wdata set window length, idle only by user rule, unchecked
// microarchitecture: a row of WINDOW cells, cell d holds the pair seen d
//   requests ago for every level and the run count at distance d; all
//   cells update in the cycle after accept and the history shifts one cell
// the winner is then found by a scan of the run counts, one distance per
//   cycle, after which the loop state updates and the result is registered
// no new request is taken while the winner scan is running
// reset: history, run counts and loop state clear, window reads 256
// a stalled receiver holds the result in the output register; the next
//   request is taken when that result is released
module repeating_loop_detector_core #(
  parameter int unsigned WINDOW = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rld_pkg::in_req_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rld_pkg::out_req_t  out_data,
  input  logic               cfg_we,
  input  logic [8:0]         cfg_wdata
);
`include "repeating_loop_detector_core_assert.svh"
  localparam int unsigned IW = $clog2(WINDOW);

  rld_pkg::state_t state_r, state_nxt;
  rld_pkg::in_req_t req_r;
  rld_pkg::cell_ctl_t ctl;
  logic [8:0] win_cfg_r, win;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [16:0] best_run_r, best_run_nxt;
  logic [8:0] best_d_r, best_d_nxt;
  logic step_r, upd;
  logic [1:0] lvl;
  logic [WINDOW:0][rld_pkg::Levels-1:0][31:0] pair;
  logic [WINDOW-1:0][15:0] run;
  logic [15:0] run_sel;
  logic out_valid_r;
  rld_pkg::out_req_t res;

  // level modulo the number of levels
  assign lvl = 2'(({30'd0, req_r.level_select}) % rld_pkg::Levels);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cfg_r <= 9'd256;
    end else if (cfg_we) begin
      win_cfg_r <= cfg_wdata;
    end
  end
  always_comb begin
    if (win_cfg_r < 9'd2) begin
      win = 9'd2;
    end else if ({23'd0, win_cfg_r} > WINDOW) begin
      win = 9'(WINDOW);
    end else begin
      win = win_cfg_r;
    end
  end

  // new pair enters cell 1 for the selected level
  always_comb begin
    pair[0] = '0;
    for (int l = 0; l < rld_pkg::Levels; l++) begin
      pair[0][l] = {req_r.event_id, req_r.size_tag};
    end
  end

  assign ctl.clear = 1'b0;
  assign ctl.step = step_r;
  assign ctl.level = lvl;
  assign ctl.event_id = req_r.event_id;
  assign ctl.size_tag = req_r.size_tag;

  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    rld_cell u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl),
      .pair_in(pair[g]), .pair_out(pair[g+1]), .run_out(run[g])
    );
  end

  assign in_ready = (state_r == rld_pkg::ST_IDLE) && !out_valid_r;
  assign run_sel = run[idx_r];

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    best_run_nxt = best_run_r;
    best_d_nxt = best_d_r;
    upd = 1'b0;
    case (state_r)
      rld_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          state_nxt = rld_pkg::ST_SCAN;
          idx_nxt = '0;
          best_run_nxt = '0;
          best_d_nxt = '0;
        end
      end
      rld_pkg::ST_SCAN: begin
        // skip the first scan cycle while the cells update
        if (!step_r) begin
          if ((32'(idx_r) + 32'd1 <= 32'(win)) &&
              ({16'd0, run_sel} > 32'(idx_r) + 32'd1) &&
              ({1'b0, run_sel} > best_run_r)) begin
            best_run_nxt = {1'b0, run_sel};
            best_d_nxt = 9'(32'(idx_r) + 32'd1);
          end
          if (32'(idx_r) == WINDOW - 1) begin
            state_nxt = rld_pkg::ST_DONE;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
      end
      rld_pkg::ST_DONE: begin
        upd = 1'b1;
        state_nxt = rld_pkg::ST_IDLE;
      end
      default: state_nxt = rld_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rld_pkg::ST_IDLE;
      step_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r <= in_valid && in_ready;
      if (upd) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    best_run_r <= best_run_nxt;
    best_d_r <= best_d_nxt;
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
  end

  rld_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .upd(upd), .level(lvl),
    .best_run(best_run_r), .best_d(best_d_r), .win(win), .res(res)
  );

  assign out_valid = out_valid_r;
  assign out_data = res;

  `RLD_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_r != rld_pkg::ST_IDLE, !in_ready)
  `RLD_ASSERT_NEXT(a_done_gives_out, clk, rst_n, state_r == rld_pkg::ST_DONE, out_valid)
  `RLD_ASSERT_IMPL(a_best_in_win, clk, rst_n, state_r == rld_pkg::ST_DONE, best_d_r <= win)
endmodule

>>> tb/testbench.sv
// testbench for the repeating loop detector: random and directed requests checked against a predictor
`timescale 1ns / 1ps

class loop_scoreboard;
  // predictor state, per level
  bit [15:0] hist_id [4][256];
  bit [15:0] hist_sz [4][256];
  bit [15:0] run_len [4][256];
  bit [8:0]  width_q [4];
  bit [8:0]  prev_width [4];
  bit [8:0]  phase_q [4];
  bit [8:0]  window_len;
  rld_pkg::out_req_t pending_results [$];
  int        errors;
  int        checked;

  function new();
    window_len = 9'd256;
    errors = 0;
    checked = 0;
    foreach (hist_id[l, d]) begin
      hist_id[l][d] = '0;
      hist_sz[l][d] = '0;
      run_len[l][d] = '0;
    end
    foreach (width_q[l]) begin
      width_q[l] = '0;
      prev_width[l] = '0;
      phase_q[l] = '0;
    end
  endfunction

  function void set_window(bit [8:0] v);
    window_len = v;
  endfunction

  // works out the result of one accepted request
  function void note_request(rld_pkg::in_req_t req);
    int unsigned lv, win, best_run, best_d, w, pw, f;
    bit inloop, noloop, diff, newite, newlop, endlop;
    int res;
    rld_pkg::out_req_t r;
    lv = req.level_select;
    win = (window_len < 2) ? 2 : ((window_len > 256) ? 256 : window_len);
    best_run = 0;
    best_d = 0;
    for (int d = 1; d <= 256; d++) begin
      if (hist_id[lv][d-1] == req.event_id && hist_sz[lv][d-1] == req.size_tag) begin
        if (run_len[lv][d-1] != 16'hFFFF) run_len[lv][d-1] = 16'(run_len[lv][d-1] + 1);
      end else begin
        run_len[lv][d-1] = '0;
      end
      if (d <= win && run_len[lv][d-1] > d && run_len[lv][d-1] > best_run) begin
        best_run = run_len[lv][d-1];
        best_d = d;
      end
    end
    for (int d = 255; d > 0; d--) begin
      hist_id[lv][d] = hist_id[lv][d-1];
      hist_sz[lv][d] = hist_sz[lv][d-1];
    end
    hist_id[lv][0] = req.event_id;
    hist_sz[lv][0] = req.size_tag;
    inloop = best_run >= win;
    if (!inloop) begin
      width_q[lv] = 9'(best_d);
      inloop = best_d > 0 && best_run > best_d;
    end
    w = width_q[lv];
    pw = prev_width[lv];
    f = phase_q[lv];
    noloop = !inloop;
    diff = pw != w;
    if (diff || f == w) f = 0;
    newite = inloop && (w == 1 || f == 0);
    if (inloop) f = (f + 1) & 9'h1FF;
    newlop = newite && diff;
    endlop = diff && pw != 0;
    if (newlop) pw = w;
    if (noloop) begin
      f = 0;
      pw = 0;
    end
    prev_width[lv] = 9'(pw);
    phase_q[lv] = 9'(f);
    res = 0;
    if (!inloop && endlop) res -= 1;
    if (inloop) res += 1;
    if (newite) res += 1;
    if (newlop) res += 1;
    if (newlop && endlop) res += 1;
    r.loop_event = res[3:0];
    r.loop_size = pw[8:0];
    pending_results.push_back(r);
  endfunction

  function void report(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endfunction

  function void check_result(rld_pkg::out_req_t got);
    rld_pkg::out_req_t want;
    checked++;
    if (pending_results.size() == 0) begin
      errors++;
      $display("mismatch: result with no request outstanding");
      return;
    end
    want = pending_results.pop_front();
    if (got.loop_event !== want.loop_event)
      report("loop_event", $signed(got.loop_event), $signed(want.loop_event));
    if (got.loop_size !== want.loop_size)
      report("loop_size", got.loop_size, want.loop_size);
  endfunction
endclass

module testbench;
  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  rld_pkg::in_req_t  in_data;
  logic     out_valid;
  logic     out_ready;
  rld_pkg::out_req_t out_data;
  logic     cfg_we;
  logic [8:0] cfg_wdata;

  loop_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int sent;

  repeating_loop_detector_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #50ms;
    $display("timeout waiting for results");
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: random stall, check each accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // sends one request, noting it in the predictor at acceptance
  // valid stays up after acceptance until the next call or drain takes it down
  task automatic send_request(bit [15:0] id, bit [15:0] sz, bit [1:0] lv);
    rld_pkg::in_req_t req;
    req.event_id = id;
    req.size_tag = sz;
    req.level_select = lv;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req);
    sent++;
  endtask

  // waits until every expected result has come, then lets the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  // window write while idle
  task automatic write_window(bit [8:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_window(v);
  endtask

  // a loop body of random pairs repeated on one level, with random content
  task automatic send_loop(int body, int reps, bit [1:0] lv);
    bit [15:0] ids [$];
    bit [15:0] szs [$];
    for (int i = 0; i < body; i++) begin
      ids.push_back(16'($urandom_range(7)));
      szs.push_back($urandom_range(3) == 0 ? 16'($urandom) : 16'd8);
    end
    for (int r = 0; r < reps; r++)
      for (int i = 0; i < body; i++) send_request(ids[i], szs[i], lv);
  endtask

  task automatic random_phase(int n);
    int start;
    start = sent;
    while (sent - start < n) begin
      case ($urandom_range(9))
        0, 1: send_request(16'($urandom), 16'($urandom), 2'($urandom));
        default: send_loop($urandom_range(1, 6), $urandom_range(2, 8), 2'($urandom));
      endcase
    end
  endtask

  initial begin
    sb = new();
    sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero pair matching the reset history, field extremes, all levels
    send_request(16'h0000, 16'h0000, 2'd0);
    send_request(16'h0000, 16'h0000, 2'd0);
    send_request(16'hFFFF, 16'hFFFF, 2'd3);
    send_request(16'hFFFF, 16'hFFFF, 2'd3);
    send_request(16'hFFFF, 16'hFFFF, 2'd3);
    send_request(16'hFFFF, 16'h0000, 2'd1);
    send_request(16'h0000, 16'hFFFF, 2'd2);
    // period two loop, then end of loop and a new loop
    for (int i = 0; i < 6; i++) send_request(16'(16'd1 + i % 2), 16'd4, 2'd1);
    for (int i = 0; i < 7; i++) send_request(16'(16'd9 + i % 3), 16'd4, 2'd1);
    send_request(16'h1234, 16'h5678, 2'd1);

    // smallest window: long runs hold the width
    write_window(9'd2);
    for (int i = 0; i < 8; i++) send_request(16'd5, 16'd5, 2'd2);
    send_loop(3, 4, 2'd0);

    // out of range values clamp
    write_window(9'd0);
    send_loop(2, 4, 2'd3);
    write_window(9'd511);
    send_loop(4, 3, 2'd3);

    write_window(9'd256);
    random_phase(400);
    send_idle_pct = 45;
    random_phase(350);
    // sender waits for every result before going on
    drain();
    write_window(9'd16);
    send_idle_pct = 0;
    recv_stall_pct = 45;
    random_phase(350);
    write_window(9'd5);
    send_idle_pct = 38;
    recv_stall_pct = 38;
    random_phase(350);
    write_window(9'd256);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_phase(350);

    drain();
    $display("covered %0d requests, %0d results checked over windows 0 to 511",
             sent, sb.checked);
    $display("idle phases: none, sender, receiver and both");
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
